### rtl/core/four_neighbor_max_min_filter_core_defines.svh
// Assertion macros shared by the filter RTL.
`ifndef FOUR_NEIGHBOR_MAX_MIN_FILTER_CORE_DEFINES_SVH
`define FOUR_NEIGHBOR_MAX_MIN_FILTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FNMM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FNMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/fnmm_pkg.sv
package fnmm_pkg;

   localparam int DEF_MAX_COLS   = 1024;
   localparam int DEF_MAX_ROWS   = 1024;
   localparam int DEF_PIXEL_BITS = 16;

   localparam int CFG_BITS       = 11;
   localparam int CFG_RESET      = 1024;
   localparam int CSR_INDEX_BITS = 2;

   localparam int OUT_POS_BITS   = 10;
   localparam int COUNT_BITS     = 21;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Result queue entries; one step makes at most three results.
   localparam int Q_DEPTH = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_ROWS = CSR_INDEX_BITS'(0),
      CSR_FRAME_COLS = CSR_INDEX_BITS'(1)
   } csr_index_type;

endpackage

### rtl/core/four_neighbor_max_min_filter_core.sv
// Streaming four-neighbor max/min filter. Pixels enter in raster order, one
// transaction per cycle unless req_stall holds them off; a result for a pixel
// is queued when its lower neighbor's transaction is accepted. Outside the
// last row the block sustains one pixel per clock while rsp_stall is low. In
// the last row a pixel's result waits for its right neighbor instead, so each
// pixel there after the first makes two results and the final pixel three
// (fewer in a single-row or single-column frame); the single result port then
// sets the rate, and a four-entry result queue sits between the two sides.
// The two previous rows live in one line memory of MAX_COLS entries, each
// entry holding a column's pixels of both rows, with two read ports
// prefetching the next pixel's column and its right neighbor.
// Writing frame_rows or frame_cols restarts the frame; values of zero act as
// one and values above the maximum act as the maximum.
`include "four_neighbor_max_min_filter_core_defines.svh"

module four_neighbor_max_min_filter_core #(
   parameter int MAX_COLS   = fnmm_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS   = fnmm_pkg::DEF_MAX_ROWS,
   parameter int PIXEL_BITS = fnmm_pkg::DEF_PIXEL_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [PIXEL_BITS-1:0]          req_pixel,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [fnmm_pkg::OUT_POS_BITS-1:0]     rsp_out_row,
   output logic [fnmm_pkg::OUT_POS_BITS-1:0]     rsp_out_col,
   output logic signed [PIXEL_BITS-1:0]          rsp_center_value,
   output logic signed [PIXEL_BITS-1:0]          rsp_neighbor_max,
   output logic signed [PIXEL_BITS-1:0]          rsp_neighbor_min,
   output logic                                  rsp_is_local_min,
   output logic [fnmm_pkg::COUNT_BITS-1:0]       rsp_local_min_count,
   output logic                                  rsp_last_of_step,
   output logic                                  rsp_frame_end,

   input  logic                                  csr_write_enable,
   input  logic [fnmm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fnmm_pkg::CFG_BITS-1:0]         csr_write_data
);
   import fnmm_pkg::*;

   localparam int ROW_BITS   = $clog2(MAX_ROWS + 1);
   localparam int COL_BITS   = $clog2(MAX_COLS + 1);
   localparam int ADDR_BITS  = $clog2(MAX_COLS);
   localparam int QPTR_BITS  = $clog2(Q_DEPTH);
   localparam int QCNT_BITS  = $clog2(Q_DEPTH + 1);
   localparam int ENTRY_BITS = 2 * PIXEL_BITS;
   localparam logic [ROW_BITS-1:0] ROWS_RESET =
      ROW_BITS'((CFG_RESET > MAX_ROWS) ? MAX_ROWS : CFG_RESET);
   localparam logic [COL_BITS-1:0] COLS_RESET =
      COL_BITS'((CFG_RESET > MAX_COLS) ? MAX_COLS : CFG_RESET);

   typedef logic signed [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]   row;
      logic [COL_BITS-1:0]   col;
      pixel_type             center;
      pixel_type             nmax;
      pixel_type             nmin;
      logic                  local_min;
      logic [COUNT_BITS-1:0] count;
      logic                  last;
      logic                  fend;
   } result_type;

   function automatic logic [ENTRY_BITS-1:0] max_min(
      input pixel_type center,
      input pixel_type up,
      input pixel_type down,
      input pixel_type left,
      input pixel_type right,
      input logic [3:0] ok
   );
      pixel_type nb [4];
      pixel_type mx;
      pixel_type mn;
      logic      found;
      nb[0] = up;
      nb[1] = down;
      nb[2] = left;
      nb[3] = right;
      mx = center;
      mn = center;
      found = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (ok[i]) begin
            if (!found) begin
               mx = nb[i];
               mn = nb[i];
               found = 1'b1;
            end else begin
               if (nb[i] > mx) mx = nb[i];
               if (nb[i] < mn) mn = nb[i];
            end
         end
      end
      return {mx, mn};
   endfunction

   // Frame geometry and position.
   logic [ROW_BITS-1:0]   rows_eff_ff, rows_eff_in;
   logic [COL_BITS-1:0]   cols_eff_ff, cols_eff_in;
   logic [ROW_BITS-1:0]   row_ff;
   logic [COL_BITS-1:0]   col_ff;
   logic [COUNT_BITS-1:0] minima_total_ff, minima_total_in;

   // Line memory and its prefetched read data.
   logic [ENTRY_BITS-1:0] line_mem [MAX_COLS];
   logic [ENTRY_BITS-1:0] rd_a_ff, rd_b_ff, wdata_ff;
   logic                  fwd_a_ff, fwd_b_ff;
   pixel_type             left0_ff, left1_ff, upleft_ff;

   // Result queue.
   result_type            q_ff [Q_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0]  cnt_ff;

   logic                  req_accept, rsp_pop;
   logic                  row_last, col_last, frame_last;
   logic [ROW_BITS-1:0]   next_row;
   logic [COL_BITS-1:0]   next_col, next_col_plus;
   logic [ADDR_BITS-1:0]  addr_a, addr_b, waddr;
   logic [ENTRY_BITS-1:0] cur_entry, nxt_entry, wdata;
   pixel_type             cur_hi, cur_lo, nxt_hi;
   logic                  v_a, v_b, v_c;
   logic [1:0]            n_new;
   result_type            res_a, res_b, res_c;
   result_type            item [Q_DEPTH];
   logic [QPTR_BITS-1:0]  slot_ofs [Q_DEPTH];

   assign req_stall  = (cnt_ff + QCNT_BITS'(n_new)) > QCNT_BITS'(Q_DEPTH);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (cnt_ff != '0);
   assign rsp_pop    = rsp_valid && !rsp_stall;

   always_comb begin
      rows_eff_in = rows_eff_ff;
      cols_eff_in = cols_eff_ff;
      if (csr_write_data == '0) begin
         rows_eff_in = ROW_BITS'(1);
         cols_eff_in = COL_BITS'(1);
      end else begin
         if (32'(csr_write_data) > MAX_ROWS) rows_eff_in = ROW_BITS'(MAX_ROWS);
         else rows_eff_in = ROW_BITS'(csr_write_data);
         if (32'(csr_write_data) > MAX_COLS) cols_eff_in = COL_BITS'(MAX_COLS);
         else cols_eff_in = COL_BITS'(csr_write_data);
      end
   end

   always_comb begin
      row_last   = (row_ff == rows_eff_ff - ROW_BITS'(1));
      col_last   = (col_ff == cols_eff_ff - COL_BITS'(1));
      frame_last = row_last && col_last;
      if (col_last) begin
         next_col = '0;
         next_row = row_last ? '0 : row_ff + ROW_BITS'(1);
      end else begin
         next_col = col_ff + COL_BITS'(1);
         next_row = row_ff;
      end
      next_col_plus = next_col + COL_BITS'(1);
      addr_a = next_col[ADDR_BITS-1:0];
      addr_b = (next_col_plus < cols_eff_ff) ? next_col_plus[ADDR_BITS-1:0] : addr_a;
      waddr  = col_ff[ADDR_BITS-1:0];

      cur_entry = fwd_a_ff ? wdata_ff : rd_a_ff;
      nxt_entry = fwd_b_ff ? wdata_ff : rd_b_ff;
      cur_hi = cur_entry[ENTRY_BITS-1:PIXEL_BITS];
      cur_lo = cur_entry[PIXEL_BITS-1:0];
      nxt_hi = nxt_entry[ENTRY_BITS-1:PIXEL_BITS];
      wdata  = {req_pixel, cur_hi};
   end

   always_comb begin
      logic [COUNT_BITS-1:0] run;
      run = minima_total_ff;

      v_a = (row_ff != '0);
      v_b = row_last && (col_ff != '0);
      v_c = frame_last;
      n_new = 2'(v_a) + 2'(v_b) + 2'(v_c);

      res_a.row    = row_ff - ROW_BITS'(1);
      res_a.col    = col_ff;
      res_a.center = cur_hi;
      {res_a.nmax, res_a.nmin} = max_min(cur_hi, cur_lo, req_pixel, upleft_ff, nxt_hi,
         {col_ff + COL_BITS'(1) < cols_eff_ff, col_ff != '0, 1'b1, row_ff > ROW_BITS'(1)});
      res_a.local_min = (res_a.nmin >= res_a.center);
      if (v_a && res_a.local_min && run != COUNT_MAX) run = run + COUNT_BITS'(1);
      res_a.count = run;
      res_a.last  = !(v_b || v_c);
      res_a.fend  = 1'b0;

      res_b.row    = row_ff;
      res_b.col    = col_ff - COL_BITS'(1);
      res_b.center = left0_ff;
      {res_b.nmax, res_b.nmin} = max_min(left0_ff, upleft_ff, req_pixel, left1_ff, req_pixel,
         {1'b1, col_ff > COL_BITS'(1), 1'b0, row_ff != '0});
      res_b.local_min = (res_b.nmin >= res_b.center);
      if (v_b && res_b.local_min && run != COUNT_MAX) run = run + COUNT_BITS'(1);
      res_b.count = run;
      res_b.last  = !v_c;
      res_b.fend  = 1'b0;

      res_c.row    = row_ff;
      res_c.col    = col_ff;
      res_c.center = req_pixel;
      {res_c.nmax, res_c.nmin} = max_min(req_pixel, cur_hi, req_pixel, left0_ff, req_pixel,
         {1'b0, col_ff != '0, 1'b0, row_ff != '0});
      res_c.local_min = (res_c.nmin >= res_c.center);
      if (v_c && res_c.local_min && run != COUNT_MAX) run = run + COUNT_BITS'(1);
      res_c.count = run;
      res_c.last  = 1'b1;
      res_c.fend  = 1'b1;

      minima_total_in = frame_last ? '0 : run;

      for (int k = 0; k < Q_DEPTH; k++) begin
         item[k] = res_c;
      end
      item[0] = v_a ? res_a : (v_b ? res_b : res_c);
      item[1] = (v_a && v_b) ? res_b : res_c;

      for (int i = 0; i < Q_DEPTH; i++) begin
         slot_ofs[i] = QPTR_BITS'(i) - wr_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_eff_ff     <= ROWS_RESET;
         cols_eff_ff     <= COLS_RESET;
         row_ff          <= '0;
         col_ff          <= '0;
         minima_total_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_ROWS: begin
               rows_eff_ff     <= rows_eff_in;
               row_ff          <= '0;
               col_ff          <= '0;
               minima_total_ff <= '0;
            end
            CSR_FRAME_COLS: begin
               cols_eff_ff     <= cols_eff_in;
               row_ff          <= '0;
               col_ff          <= '0;
               minima_total_ff <= '0;
            end
            default: begin
            end
         endcase
      end else if (req_accept) begin
         row_ff          <= next_row;
         col_ff          <= next_col;
         minima_total_ff <= minima_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         line_mem[waddr] <= wdata;
         rd_a_ff         <= line_mem[addr_a];
         rd_b_ff         <= line_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         wdata_ff  <= wdata;
         fwd_a_ff  <= (addr_a == waddr);
         fwd_b_ff  <= (addr_b == waddr);
         upleft_ff <= cur_hi;
         left1_ff  <= left0_ff;
         left0_ff  <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (req_accept) wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(n_new);
         if (rsp_pop) rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         cnt_ff <= cnt_ff + (req_accept ? QCNT_BITS'(n_new) : '0) - QCNT_BITS'(rsp_pop);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Q_DEPTH; i++) begin
         if (req_accept && (QCNT_BITS'(slot_ofs[i]) < QCNT_BITS'(n_new))) begin
            q_ff[i] <= item[slot_ofs[i]];
         end
      end
   end

   always_comb begin
      rsp_out_row         = OUT_POS_BITS'(q_ff[rd_ptr_ff].row);
      rsp_out_col         = OUT_POS_BITS'(q_ff[rd_ptr_ff].col);
      rsp_center_value    = q_ff[rd_ptr_ff].center;
      rsp_neighbor_max    = q_ff[rd_ptr_ff].nmax;
      rsp_neighbor_min    = q_ff[rd_ptr_ff].nmin;
      rsp_is_local_min    = q_ff[rd_ptr_ff].local_min;
      rsp_local_min_count = q_ff[rd_ptr_ff].count;
      rsp_last_of_step    = q_ff[rd_ptr_ff].last;
      rsp_frame_end       = q_ff[rd_ptr_ff].fend;
   end

   `FNMM_ASSERT_SAME(a_frame_end_is_last, clock, reset,
      rsp_valid && rsp_frame_end, rsp_last_of_step,
      "Frame end result is not the last result of its transaction.")

   `FNMM_ASSERT_NEXT(a_frame_wraps, clock, reset,
      req_accept && frame_last,
      row_ff == '0 && col_ff == '0 && minima_total_ff == '0,
      "Position or minima count did not restart after the final pixel.")

   `FNMM_ASSERT_NEXT(a_queue_fill, clock, reset,
      req_accept && !rsp_pop,
      cnt_ff == $past(cnt_ff) + QCNT_BITS'($past(n_new)),
      "Result queue count does not match the results of the transaction.")

endmodule

### verif/four_neighbor_max_min_filter_core_test.sv
module four_neighbor_max_min_filter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fnmm_pkg::*;

   localparam int PW = DEF_PIXEL_BITS;
   localparam int COL_LIMIT = DEF_MAX_COLS;
   localparam int ROW_LIMIT = DEF_MAX_ROWS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_3 = 2'd3;
   localparam logic [PW-1:0] MOST_NEG = {1'b1, {(PW-1){1'b0}}};
   localparam logic [PW-1:0] MOST_POS = ~MOST_NEG;
   localparam logic signed [PW-1:0] NO_PIXEL = '0;

   typedef struct packed {
      logic [OUT_POS_BITS-1:0] row;
      logic [OUT_POS_BITS-1:0] col;
      logic signed [PW-1:0]    center;
      logic signed [PW-1:0]    hi;
      logic signed [PW-1:0]    lo;
      logic                    is_min;
      logic [COUNT_BITS-1:0]   count;
      logic                    last_step;
      logic                    fend;
   } filter_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [PW-1:0]      req_pixel = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [OUT_POS_BITS-1:0]   rsp_out_row;
   logic [OUT_POS_BITS-1:0]   rsp_out_col;
   logic signed [PW-1:0]      rsp_center_value;
   logic signed [PW-1:0]      rsp_neighbor_max;
   logic signed [PW-1:0]      rsp_neighbor_min;
   logic                      rsp_is_local_min;
   logic [COUNT_BITS-1:0]     rsp_local_min_count;
   logic                      rsp_last_of_step;
   logic                      rsp_frame_end;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_write_data = '0;

   logic [PW-1:0]     pixel_queue [$];
   filter_result_type results_due [$];

   logic [CFG_BITS-1:0]    rows_cfg = 11'(CFG_RESET);
   logic [CFG_BITS-1:0]    cols_cfg = 11'(CFG_RESET);
   logic signed [PW-1:0]   line_mem [2*COL_LIMIT];
   logic signed [PW-1:0]   prev_pix [2];
   int unsigned            cur_row = 0;
   int unsigned            cur_col = 0;
   logic [COUNT_BITS-1:0]  minima = '0;
   logic signed [PW-1:0]   nb_val [4];
   bit                     nb_ok [4];

   int          failures = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          send_wait = 0;
   int          stall_left = 0;
   logic        req_taken = 1'b0;
   bit          hold_off = 1'b0;
   bit          pressure_go = 1'b0;
   int unsigned pixels_pushed = 0;

   four_neighbor_max_min_filter_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_pixel           (req_pixel),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_row         (rsp_out_row),
      .rsp_out_col         (rsp_out_col),
      .rsp_center_value    (rsp_center_value),
      .rsp_neighbor_max    (rsp_neighbor_max),
      .rsp_neighbor_min    (rsp_neighbor_min),
      .rsp_is_local_min    (rsp_is_local_min),
      .rsp_local_min_count (rsp_local_min_count),
      .rsp_last_of_step    (rsp_last_of_step),
      .rsp_frame_end       (rsp_frame_end),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned clamp_size(logic [CFG_BITS-1:0] value, int unsigned limit);
      if (value == 0) return 1;
      if (int'(value) > int'(limit)) return limit;
      return int'(value);
   endfunction

   function automatic int slot(int unsigned row, int unsigned col);
      return int'((row % 2) * COL_LIMIT + (col % COL_LIMIT));
   endfunction

   function automatic void set_nbrs(logic signed [PW-1:0] up, bit up_ok,
                                    logic signed [PW-1:0] down, bit down_ok,
                                    logic signed [PW-1:0] left, bit left_ok,
                                    logic signed [PW-1:0] right, bit right_ok);
      nb_val[0] = up;
      nb_ok[0] = up_ok;
      nb_val[1] = down;
      nb_ok[1] = down_ok;
      nb_val[2] = left;
      nb_ok[2] = left_ok;
      nb_val[3] = right;
      nb_ok[3] = right_ok;
   endfunction

   function automatic filter_result_type make_result(int unsigned row, int unsigned col,
                                                     logic signed [PW-1:0] center, bit fend);
      filter_result_type res;
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      bit found;
      hi = center;
      lo = center;
      found = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (nb_ok[i]) begin
            if (!found || nb_val[i] > hi) hi = nb_val[i];
            if (!found || nb_val[i] < lo) lo = nb_val[i];
            found = 1'b1;
         end
      end
      res.row = OUT_POS_BITS'(row);
      res.col = OUT_POS_BITS'(col);
      res.center = center;
      res.hi = hi;
      res.lo = lo;
      res.is_min = (lo >= center);
      if (res.is_min && minima != COUNT_MAX) minima = minima + 1'b1;
      res.count = minima;
      res.last_step = 1'b0;
      res.fend = fend;
      return res;
   endfunction

   task automatic filter_pixel(input logic signed [PW-1:0] p);
      filter_result_type step_res [3];
      int unsigned nrows;
      int unsigned ncols;
      int unsigned r;
      int unsigned c;
      int n;
      nrows = clamp_size(rows_cfg, ROW_LIMIT);
      ncols = clamp_size(cols_cfg, COL_LIMIT);
      r = cur_row;
      c = cur_col;
      n = 0;
      if (r >= nrows || c >= ncols) begin
         r = 0;
         c = 0;
         minima = '0;
      end
      if (r >= 1) begin
         set_nbrs(line_mem[slot(r, c)], r >= 2, p, 1'b1,
                  c > 0 ? line_mem[slot(r - 1, c - 1)] : NO_PIXEL, c > 0,
                  c + 1 < ncols ? line_mem[slot(r - 1, c + 1)] : NO_PIXEL, c + 1 < ncols);
         step_res[n] = make_result(r - 1, c, line_mem[slot(r - 1, c)], 1'b0);
         n++;
      end
      if (r == nrows - 1) begin
         if (c >= 1) begin
            set_nbrs(r >= 1 ? line_mem[slot(r - 1, c - 1)] : NO_PIXEL, r >= 1,
                     NO_PIXEL, 1'b0, prev_pix[1], c >= 2, p, 1'b1);
            step_res[n] = make_result(r, c - 1, prev_pix[0], 1'b0);
            n++;
         end
         if (c == ncols - 1) begin
            set_nbrs(r >= 1 ? line_mem[slot(r - 1, c)] : NO_PIXEL, r >= 1,
                     NO_PIXEL, 1'b0, prev_pix[0], c >= 1, NO_PIXEL, 1'b0);
            step_res[n] = make_result(r, c, p, 1'b1);
            n++;
         end
      end
      line_mem[slot(r, c)] = p;
      prev_pix[1] = prev_pix[0];
      prev_pix[0] = p;
      for (int i = 0; i < n; i++) begin
         step_res[i].last_step = (i == n - 1);
         results_due.push_back(step_res[i]);
      end
      c++;
      if (c >= ncols) begin
         c = 0;
         r++;
         if (r >= nrows) begin
            r = 0;
            minima = '0;
         end
      end
      cur_row = r;
      cur_col = c;
   endtask

   task automatic apply_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CFG_BITS-1:0] value);
      if (index == CSR_FRAME_ROWS) rows_cfg = value;
      else if (index == CSR_FRAME_COLS) cols_cfg = value;
      else return;
      cur_row = 0;
      cur_col = 0;
      minima = '0;
   endtask

   task automatic report_failure(input string msg);
      $display("ERROR: %s", msg);
      failures++;
   endtask

   task automatic compare_field(input string name, input int got, input int want,
                                input filter_result_type ref_res);
      if (got != want)
         report_failure($sformatf("%s at row %0d col %0d: got %0d, expected %0d",
                                  name, ref_res.row, ref_res.col, got, want));
   endtask

   task automatic check_result();
      filter_result_type want;
      if (results_due.size() == 0) begin
         report_failure($sformatf("transaction for row %0d col %0d with none expected",
                                  rsp_out_row, rsp_out_col));
         return;
      end
      want = results_due.pop_front();
      compare_field("out_row", int'(rsp_out_row), int'(want.row), want);
      compare_field("out_col", int'(rsp_out_col), int'(want.col), want);
      compare_field("center_value", int'(rsp_center_value), int'(want.center), want);
      compare_field("neighbor_max", int'(rsp_neighbor_max), int'(want.hi), want);
      compare_field("neighbor_min", int'(rsp_neighbor_min), int'(want.lo), want);
      compare_field("is_local_min", int'(rsp_is_local_min), int'(want.is_min), want);
      compare_field("local_min_count", int'(rsp_local_min_count), int'(want.count), want);
      compare_field("last_of_step", int'(rsp_last_of_step), int'(want.last_step), want);
      compare_field("frame_end", int'(rsp_frame_end), int'(want.fend), want);
   endtask

   function automatic int pick_gap(int pct);
      if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 15) == 0) return int'($urandom_range(10, 40));
      return int'($urandom_range(1, 3));
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 10;
         2: return 30;
         default: return 60;
      endcase
   endfunction

   function automatic logic [PW-1:0] make_pixel(int mode);
      case (mode)
         0: return PW'($urandom);
         1: return PW'($urandom_range(0, 6) - 3);
         2: begin
            case ($urandom_range(0, 3))
               0: return MOST_NEG;
               1: return MOST_POS;
               2: return '0;
               default: return '1;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1) == 1) return MOST_NEG + PW'($urandom_range(0, 3));
            return MOST_POS - PW'($urandom_range(0, 3));
         end
      endcase
   endfunction

   task automatic push_pixels(input int unsigned count, input int mode);
      for (int unsigned i = 0; i < count; i++) pixel_queue.push_back(make_pixel(mode));
      pixels_pushed += count;
   endtask

   task automatic settle();
      while (pixel_queue.size() != 0 || req_valid || results_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CFG_BITS-1:0] value);
      settle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      apply_csr(index, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (send_wait != 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_pixel <= pixel_queue.pop_front();
            send_wait = pick_gap(send_idle_pct);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) stall_left = pick_gap(recv_idle_pct);
      else stall_left--;
      rsp_stall <= hold_off || (stall_left != 0);
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) filter_pixel(req_pixel);
      if (!reset && rsp_valid && !rsp_stall) check_result();
   end

   // The receiver holds off long enough for the result queue to fill and the
   // input side to stall.
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [CFG_BITS-1:0] rows_val;
      logic [CFG_BITS-1:0] cols_val;
      int unsigned frame_px;
      int unsigned start_count;
      int unsigned split;
      int frames;
      int mode;
      bit broken;

      for (int i = 0; i < 2; i++) prev_pix[i] = '0;
      for (int i = 0; i < 2 * COL_LIMIT; i++) line_mem[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 25;
      pixel_queue.push_back(MOST_NEG);
      pixel_queue.push_back(MOST_POS);
      write_csr(CSR_FRAME_ROWS, 11'd1);
      write_csr(CSR_FRAME_COLS, 11'd1);
      pixel_queue.push_back(MOST_NEG);
      pixel_queue.push_back(MOST_POS);
      write_csr(CSR_FRAME_ROWS, 11'd0);
      write_csr(CSR_FRAME_COLS, 11'd0);
      pixel_queue.push_back('0);
      pixel_queue.push_back('1);
      write_csr(CSR_FRAME_ROWS, 11'd1);
      write_csr(CSR_FRAME_COLS, 11'd4);
      pixel_queue.push_back(MOST_POS);
      pixel_queue.push_back(MOST_NEG);
      pixel_queue.push_back(16'd7);
      pixel_queue.push_back(16'd7);
      write_csr(CSR_FRAME_ROWS, 11'd4);
      write_csr(CSR_FRAME_COLS, 11'd1);
      pixel_queue.push_back(-16'sd5);
      pixel_queue.push_back(16'd3);
      pixel_queue.push_back(16'd3);
      pixel_queue.push_back(MOST_NEG);
      write_csr(CSR_FRAME_ROWS, 11'd3);
      write_csr(CSR_FRAME_COLS, 11'd3);
      pixel_queue.push_back(16'd1);
      pixel_queue.push_back(16'd2);
      pixel_queue.push_back(16'd1);
      pixel_queue.push_back(16'd2);
      write_csr(CSR_UNMAPPED_3, 11'd5);
      pixel_queue.push_back(16'd0);
      pixel_queue.push_back(16'd2);
      pixel_queue.push_back(16'd1);
      pixel_queue.push_back(MOST_POS);
      pixel_queue.push_back(16'd1);

      write_csr(CSR_FRAME_ROWS, 11'd1);
      write_csr(CSR_FRAME_COLS, 11'd2047);
      send_idle_pct = 0;
      recv_idle_pct = 20;
      push_pixels(100, 0);
      pressure_go = 1'b1;
      write_csr(CSR_FRAME_ROWS, 11'd2047);
      write_csr(CSR_FRAME_COLS, 11'd1);
      send_idle_pct = 10;
      push_pixels(40, 3);
      write_csr(CSR_FRAME_ROWS, 11'd1024);
      write_csr(CSR_FRAME_COLS, 11'd2);
      push_pixels(40, 0);

      start_count = pixels_pushed;
      while (pixels_pushed - start_count < 240) begin
         rows_val = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
         cols_val = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
         write_csr(CSR_FRAME_ROWS, rows_val);
         write_csr(CSR_FRAME_COLS, cols_val);
         send_idle_pct = pick_idle_pct();
         recv_idle_pct = pick_idle_pct();
         frame_px = clamp_size(rows_val, ROW_LIMIT) * clamp_size(cols_val, COL_LIMIT);
         frames = int'($urandom_range(1, 3));
         broken = 1'b0;
         for (int f = 0; f < frames && !broken; f++) begin
            mode = int'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
               0: begin
                  push_pixels($urandom_range(0, frame_px - 1), mode);
                  broken = 1'b1;
               end
               1: begin
                  split = $urandom_range(0, frame_px - 1);
                  push_pixels(split, mode);
                  write_csr(CSR_UNMAPPED_2, 11'($urandom));
                  push_pixels(frame_px - split, mode);
               end
               default: push_pixels(frame_px, mode);
            endcase
         end
      end

      settle();
      repeat (12) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
